// ===== design/sqvs_pkg.sv =====
// sqvs_pkg: shared types, constants and the sine table function for the sprite
// quad vertex setup block; no dependencies
`timescale 1ns / 1ps

package sqvs_pkg;

	// numeric widths
	localparam int MW        = 36;   // divider numerator, signed
	localparam int DEN_W     = 18;   // divider denominator
	localparam int Q_W       = 16;   // quotient / output coordinate
	localparam int SIN_W     = 15;   // unsigned Q1.14 table entry
	localparam int DIV_LAT   = Q_W + 1;

	// angle constants, sixteenths of a degree
	localparam int FULL_TURN    = 5760;
	localparam int QUARTER_TURN = 1440;

	// quarter turn / 1440 = (n >> 5) / 45, done as multiply by reciprocal
	localparam int RECIP_SHIFT = 25;
	localparam int RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP45 = RECIP_W'((2**RECIP_SHIFT + 44) / 45);

	// pi/2 in Q28
	localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

	// configuration register indexes
	localparam logic [7:0] REG_VIEWPORT_W = 8'd0;
	localparam logic [7:0] REG_VIEWPORT_H = 8'd1;
	localparam logic [7:0] REG_TEXTURE_W  = 8'd2;
	localparam logic [7:0] REG_TEXTURE_H  = 8'd3;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        size_w;
		logic [15:0]        size_h;
		logic [12:0]        angle;
		logic [12:0]        tex_x;
		logic [12:0]        tex_y;
		logic [12:0]        tex_w;
		logic [12:0]        tex_h;
	} sprite_t;

	typedef struct packed {
		logic [1:0]         corner;
		logic signed [15:0] ndc_x;
		logic signed [15:0] ndc_y;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic               last;
	} vertex_t;

	typedef struct packed {
		logic [7:0]  index;
		logic [13:0] wdata;
	} cfg_write_t;

	// effective sizes, zero already replaced by one
	typedef struct packed {
		logic [13:0] vw;
		logic [13:0] vh;
		logic [13:0] tw;
		logic [13:0] th;
	} cfg_t;

	// sprite centre in half-pixel units, sizes and texel edges
	typedef struct packed {
		logic signed [17:0] cx;
		logic signed [17:0] cy;
		logic [15:0]        sw;
		logic [15:0]        sh;
		logic [13:0]        tx0;
		logic [13:0]        tx1;
		logic [13:0]        ty0;
		logic [13:0]        ty1;
	} geo_t;

	// one classified sprite handed from front to back
	typedef struct packed {
		geo_t               geo;
		logic signed [15:0] sn;
		logic signed [15:0] cs;
	} setup_t;

	// sine of a Q28 angle by Taylor series to the 13th power, rounded to Q14
	function automatic logic [SIN_W-1:0] sine_from_x(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		x2   = (x * x) >> 28;
		term = x;
		sum  = x;
		term = ((term * x2) >> 28) / 6;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 28) / 20;
		sum  = sum + term;
		term = ((term * x2) >> 28) / 42;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 28) / 72;
		sum  = sum + term;
		term = ((term * x2) >> 28) / 110;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 28) / 156;
		sum  = sum + term;
		sum  = (sum + 64'd8192) >> 14;
		if (sum > 64'd16384) begin
			sum = 64'd16384;
		end
		return SIN_W'(sum);
	endfunction

endpackage

// ===== design/sqvs_stream_if.sv =====
// sqvs_stream_if: valid/ready channel with a typed payload
// no dependencies; payload type set per instance
`timescale 1ns / 1ps

interface sqvs_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/sqvs_fifo.sv =====
// sqvs_fifo: small register queue between the front and back parts
// depends on nothing but its type parameter
`timescale 1ns / 1ps

module sqvs_fifo #(
	parameter int  DEPTH = 4,
	parameter type T     = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     push_data,
	output logic full,
	input  logic pop,
	output T     pop_data,
	output logic empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== design/sqvs_front.sv =====
// sqvs_front: accepts sprites, reduces the angle, looks up sine and cosine
// and forms the centre; depends on sqvs_pkg
`timescale 1ns / 1ps

module sqvs_front #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sqvs_pkg::sprite_t in_data,
	output logic              push,
	output sqvs_pkg::setup_t  push_data,
	input  logic              full
);
	import sqvs_pkg::*;

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int N_W   = $clog2(QUARTER_TURN * SINE_TABLE_DEPTH + 721);
	localparam int M_W   = N_W - 5;
	localparam int P_W   = M_W + RECIP_W;
	localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(SINE_TABLE_DEPTH);

	// quarter-wave sine table
	logic [SIN_W-1:0] sine_rom [SINE_TABLE_DEPTH + 1];
	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam longint unsigned XK =
			(longint'(k) * HALF_PI_Q28) / SINE_TABLE_DEPTH;
		assign sine_rom[k] = sine_from_x(XK);
	end

	logic             adv;
	logic             v_s1, v_s2, v_s3, v_s4;
	geo_t             geo_in, geo_s1, geo_s2, geo_s3, geo_s4;
	logic [12:0]      a_red;
	logic [1:0]       quad;
	logic [10:0]      rest;
	logic [1:0]       quad_s1, quad_s2, quad_s3, quad_s4;
	logic [10:0]      rest_s1;
	logic [N_W-1:0]   n_s2;
	logic [P_W-1:0]   prod;
	logic [IDX_W-1:0] idx_s3;
	logic [SIN_W-1:0] s0_s4, c0_s4;
	logic [SIN_W-1:0] sin_mag, cos_mag;
	logic [15:0]      sin_pos, cos_pos;

	// the four stages move together, held while the last stage holds a sprite and the queue is full
	assign adv      = !v_s4 || !full;
	assign in_ready = adv;
	assign push     = v_s4 && !full;

	// angle reduction to quadrant and rest
	always_comb begin
		a_red = (in_data.angle >= 13'(FULL_TURN)) ?
			in_data.angle - 13'(FULL_TURN) : in_data.angle;
		if (a_red >= 13'(3 * QUARTER_TURN)) begin
			quad = 2'd3;
			rest = 11'(a_red - 13'(3 * QUARTER_TURN));
		end else if (a_red >= 13'(2 * QUARTER_TURN)) begin
			quad = 2'd2;
			rest = 11'(a_red - 13'(2 * QUARTER_TURN));
		end else if (a_red >= 13'(QUARTER_TURN)) begin
			quad = 2'd1;
			rest = 11'(a_red - 13'(QUARTER_TURN));
		end else begin
			quad = 2'd0;
			rest = a_red[10:0];
		end
	end

	// centre and texel edges
	always_comb begin
		geo_in.cx  = {in_data.pos_x[15], in_data.pos_x, 1'b0} + {2'b00, in_data.size_w};
		geo_in.cy  = {in_data.pos_y[15], in_data.pos_y, 1'b0} + {2'b00, in_data.size_h};
		geo_in.sw  = in_data.size_w;
		geo_in.sh  = in_data.size_h;
		geo_in.tx0 = {1'b0, in_data.tex_x};
		geo_in.tx1 = {1'b0, in_data.tex_x} + {1'b0, in_data.tex_w};
		geo_in.ty0 = {1'b0, in_data.tex_y};
		geo_in.ty1 = {1'b0, in_data.tex_y} + {1'b0, in_data.tex_h};
	end

	// table index: (rest * depth + 720) / 1440 by reciprocal of 45
	assign prod = P_W'(n_s2[N_W-1:5]) * P_W'(RECIP45);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage payload and table read
	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1  <= geo_in;
			quad_s1 <= quad;
			rest_s1 <= rest;
			geo_s2  <= geo_s1;
			quad_s2 <= quad_s1;
			n_s2    <= N_W'(32'(rest_s1) * 32'(SINE_TABLE_DEPTH) + 32'd720);
			geo_s3  <= geo_s2;
			quad_s3 <= quad_s2;
			idx_s3  <= prod[RECIP_SHIFT +: IDX_W];
			geo_s4  <= geo_s3;
			quad_s4 <= quad_s3;
			s0_s4   <= sine_rom[idx_s3];
			c0_s4   <= sine_rom[TOP_IDX - idx_s3];
		end
	end

	// quadrant folding: odd quadrants swap, sign per quadrant
	always_comb begin
		sin_mag = quad_s4[0] ? c0_s4 : s0_s4;
		cos_mag = quad_s4[0] ? s0_s4 : c0_s4;
		sin_pos = {1'b0, sin_mag};
		cos_pos = {1'b0, cos_mag};
		push_data.geo = geo_s4;
		push_data.sn  = quad_s4[1] ? 16'(-sin_pos) : sin_pos;
		push_data.cs  = (quad_s4[1] ^ quad_s4[0]) ? 16'(-cos_pos) : cos_pos;
	end
endmodule

// ===== design/sqvs_div.sv =====
// sqvs_div: pipelined restoring divider, one quotient bit per stage,
// saturating the quotient to [0, 2^16-1]; depends on sqvs_pkg
`timescale 1ns / 1ps

module sqvs_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [sqvs_pkg::MW-1:0] num,
	input  logic [sqvs_pkg::DEN_W-1:0]    den,
	output logic [sqvs_pkg::Q_W-1:0]      quo
);
	import sqvs_pkg::*;

	localparam int REM_W = DEN_W + Q_W;

	logic [REM_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W + 1];
	logic             neg_s [Q_W + 1];
	logic             big_s [Q_W + 1];
	logic [MW-1:0]    den_top;

	assign den_top = MW'(den) << Q_W;

	// entry stage: range check against the full quotient span
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= num[MW-1];
			big_s[0] <= !num[MW-1] && ($unsigned(num) >= den_top);
			rem_s[0] <= REM_W'(num);
			quo_s[0] <= '0;
		end
	end

	// one trial subtract per stage, msb first
	for (genvar i = 1; i <= Q_W; i++) begin : g_step
		logic [REM_W-1:0] trial;
		logic             fit;
		assign trial = REM_W'(den) << (Q_W - i);
		assign fit   = (rem_s[i-1] >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i] <= neg_s[i-1];
				big_s[i] <= big_s[i-1];
				quo_s[i] <= fit ? (quo_s[i-1] | (Q_W'(1) << (Q_W - i))) : quo_s[i-1];
			end
		end

		if (i < Q_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= fit ? rem_s[i-1] - trial : rem_s[i-1];
				end
			end
		end
	end

	// saturation
	assign quo = neg_s[Q_W] ? '0 : (big_s[Q_W] ? '1 : quo_s[Q_W]);
endmodule

// ===== design/sqvs_back.sv =====
// sqvs_back: expands a sprite into four corners, rotates and maps them,
// divides through four divider pipelines; depends on sqvs_pkg, sqvs_div
`timescale 1ns / 1ps

module sqvs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sqvs_pkg::cfg_t    cfg,
	input  logic              empty,
	input  sqvs_pkg::setup_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output sqvs_pkg::vertex_t out_data
);
	import sqvs_pkg::*;

	logic                 en;
	logic                 issue;
	logic [1:0]           k_q;
	logic signed [16:0]   dx, dy;
	logic                 v_b1, v_b2;
	logic [1:0]           k_b1, k_b2;
	logic signed [32:0]   p_cdx_b1, p_sdy_b1, p_sdx_b1, p_cdy_b1;
	logic signed [17:0]   cx_b1, cy_b1;
	logic [13:0]          tu_b1, tv_b1;
	logic signed [MW-1:0] x_pos, y_pos, off_x, off_y, u_num, v_num;
	logic signed [MW-1:0] mx_b2, my_b2, mu_b2, mv_b2;
	logic [DEN_W-1:0]     den_x, den_y, den_u, den_v;
	logic                 v_d [DIV_LAT];
	logic [1:0]           k_d [DIV_LAT];
	logic [Q_W-1:0]       qx, qy, qu, qv;
	logic                 out_valid_q;
	vertex_t              out_q;

	// whole back pipeline moves when the output register is free or taken
	assign en        = !out_valid_q || out_ready;
	assign issue     = en && !empty;
	assign pop       = issue && (k_q == 2'd3);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// corner offsets
	always_comb begin
		dx = k_q[0] ? signed'({1'b0, head.geo.sw}) : -signed'({1'b0, head.geo.sw});
		dy = k_q[1] ? signed'({1'b0, head.geo.sh}) : -signed'({1'b0, head.geo.sh});
	end

	// mapping offsets and divisors from configuration
	always_comb begin
		off_x = signed'((MW'(cfg.vw) << 18) + (MW'(cfg.vw) << 3));
		off_y = signed'((MW'(cfg.vh) << 19) + (MW'(cfg.vh) << 18) +
			(MW'(cfg.vh) << 3) - MW'(1));
		den_x = {cfg.vw, 4'b0000};
		den_y = {cfg.vh, 4'b0000};
		den_u = {4'b0000, cfg.tw};
		den_v = {4'b0000, cfg.th};
	end

	// rotated positions and texture numerators
	always_comb begin
		x_pos = (MW'(cx_b1) <<< 14) + MW'(p_cdx_b1) - MW'(p_sdy_b1);
		y_pos = (MW'(cy_b1) <<< 14) + MW'(p_sdx_b1) + MW'(p_cdy_b1);
		u_num = signed'((MW'(tu_b1) << 14) + MW'(cfg.tw >> 1));
		v_num = signed'((MW'(tv_b1) << 14) + MW'(cfg.th >> 1));
	end

	// corner counter and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 2'd0;
			v_b1        <= 1'b0;
			v_b2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				v_d[i] <= 1'b0;
			end
		end else if (en) begin
			if (issue) begin
				k_q <= k_q + 2'd1;
			end
			v_b1 <= issue;
			v_b2 <= v_b1;
			v_d[0] <= v_b2;
			for (int i = 1; i < DIV_LAT; i++) begin
				v_d[i] <= v_d[i-1];
			end
			out_valid_q <= v_d[DIV_LAT-1];
		end
	end

	// products, numerators and corner tags
	always_ff @(posedge clk) begin
		if (en) begin
			k_b1     <= k_q;
			p_cdx_b1 <= head.cs * dx;
			p_sdy_b1 <= head.sn * dy;
			p_sdx_b1 <= head.sn * dx;
			p_cdy_b1 <= head.cs * dy;
			cx_b1    <= head.geo.cx;
			cy_b1    <= head.geo.cy;
			tu_b1    <= k_q[0] ? head.geo.tx1 : head.geo.tx0;
			tv_b1    <= k_q[1] ? head.geo.ty1 : head.geo.ty0;
			k_b2     <= k_b1;
			mx_b2    <= x_pos + off_x;
			my_b2    <= off_y - y_pos;
			mu_b2    <= u_num;
			mv_b2    <= v_num;
			k_d[0]   <= k_b2;
			for (int i = 1; i < DIV_LAT; i++) begin
				k_d[i] <= k_d[i-1];
			end
			out_q.corner <= k_d[DIV_LAT-1];
			out_q.ndc_x  <= signed'(qx ^ 16'h8000);
			out_q.ndc_y  <= signed'(qy ^ 16'h8000);
			out_q.tex_u  <= qu;
			out_q.tex_v  <= qv;
			out_q.last   <= (k_d[DIV_LAT-1] == 2'd3);
		end
	end

	// divider pipelines
	sqvs_div u_div_x (.clk(clk), .en(en), .num(mx_b2), .den(den_x), .quo(qx));
	sqvs_div u_div_y (.clk(clk), .en(en), .num(my_b2), .den(den_y), .quo(qy));
	sqvs_div u_div_u (.clk(clk), .en(en), .num(mu_b2), .den(den_u), .quo(qu));
	sqvs_div u_div_v (.clk(clk), .en(en), .num(mv_b2), .den(den_v), .quo(qv));
endmodule

// ===== design/sprite_quad_vertex_setup.sv =====
// sprite_quad_vertex_setup: rotated sprite to four device-space vertices
// depends on sqvs_pkg, sqvs_stream_if, sqvs_fifo, sqvs_front, sqvs_back
//
// Channels: sprite (sink, sprite_t) takes one sprite per transfer; vertex
// (source, vertex_t) gives its four corners in strip order top-left,
// top-right, bottom-left, bottom-right, last set on the fourth; cfg (sink,
// cfg_write_t) writes viewport_width/height, texture_width/height by index.
// cfg is always ready; write it only while no sprite is in flight.
// Throughput: one vertex per cycle while the vertex receiver is ready and a
// sprite is queued, set by four corner issues per sprite into the shared
// rotation and divider pipelines. Path from sprite transfer to first vertex:
// 4 front stages (angle, index, table read), the queue, 2 rotation stages,
// 17 divider stages and the output register.
// Reset clears all valids, the queue and the corner counter, and loads the
// registers with 1920, 1080, 256, 256.
// A stalled vertex receiver freezes the back pipeline; the queue then fills
// and the sprite channel drops ready.
`timescale 1ns / 1ps

module sprite_quad_vertex_setup #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input logic          clk,
	input logic          arst_n,
	sqvs_stream_if.sink   sprite,
	sqvs_stream_if.source vertex,
	sqvs_stream_if.sink   cfg
);
	import sqvs_pkg::*;

	logic [13:0]   vw_q, vh_q, tw_q, th_q;
	cfg_t          cfg_eff;
	cfg_write_t    cfg_wr;
	sprite_t       sprite_data;
	vertex_t       vertex_data;
	setup_t        push_data, head;
	logic          push, full, pop, empty;

	assign cfg.ready    = 1'b1;
	assign cfg_wr       = cfg.data;
	assign sprite_data  = sprite.data;
	assign vertex.data  = vertex_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q <= 14'd1920;
			vh_q <= 14'd1080;
			tw_q <= 14'd256;
			th_q <= 14'd256;
		end else if (cfg.valid) begin
			unique case (cfg_wr.index)
				REG_VIEWPORT_W: vw_q <= cfg_wr.wdata;
				REG_VIEWPORT_H: vh_q <= cfg_wr.wdata;
				REG_TEXTURE_W:  tw_q <= cfg_wr.wdata;
				REG_TEXTURE_H:  th_q <= cfg_wr.wdata;
				default: ;
			endcase
		end
	end

	// zero size used as one
	always_comb begin
		cfg_eff.vw = (vw_q == '0) ? 14'd1 : vw_q;
		cfg_eff.vh = (vh_q == '0) ? 14'd1 : vh_q;
		cfg_eff.tw = (tw_q == '0) ? 14'd1 : tw_q;
		cfg_eff.th = (th_q == '0) ? 14'd1 : th_q;
	end

	sqvs_front #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sprite.valid),
		.in_ready (sprite.ready),
		.in_data  (sprite_data),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	sqvs_fifo #(
		.DEPTH(4),
		.T    (setup_t)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (head),
		.empty    (empty)
	);

	sqvs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_eff),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.out_valid(vertex.valid),
		.out_ready(vertex.ready),
		.out_data (vertex_data)
	);
endmodule

// ===== design/sqvs_checker.sv =====
// sqvs_checker: port-level checks on the vertex stream, bound to the top
// depends on sqvs_pkg
`timescale 1ns / 1ps

module sqvs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sprite_valid,
	input logic              sprite_ready,
	input logic              vertex_valid,
	input logic              vertex_ready,
	input sqvs_pkg::vertex_t vertex_data
);
	import sqvs_pkg::*;

	logic       sprite_xfer, vertex_xfer;
	logic [1:0] exp_corner_q;
	logic [7:0] pending_q;

	assign sprite_xfer = sprite_valid && sprite_ready;
	assign vertex_xfer = vertex_valid && vertex_ready;

	// expected corner and vertices owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_corner_q <= 2'd0;
			pending_q    <= '0;
		end else begin
			if (vertex_xfer) begin
				exp_corner_q <= exp_corner_q + 2'd1;
			end
			pending_q <= pending_q + (sprite_xfer ? 8'd4 : 8'd0) - (vertex_xfer ? 8'd1 : 8'd0);
		end
	end

	a_corner_order: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_xfer |-> (vertex_data.corner == exp_corner_q) &&
			(vertex_data.last == (exp_corner_q == 2'd3)))
		else $error("vertex corner out of strip order");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_xfer |-> (pending_q != 8'd0))
		else $error("vertex without an accepted sprite");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_ready |=> vertex_valid)
		else $error("vertex valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_ready |=> $stable(vertex_data))
		else $error("vertex payload changed while stalled");
endmodule

bind sprite_quad_vertex_setup sqvs_checker u_sqvs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sprite_valid(sprite.valid),
	.sprite_ready(sprite.ready),
	.vertex_valid(vertex.valid),
	.vertex_ready(vertex.ready),
	.vertex_data (vertex.data)
);
